// ----- rtl/core/nywc_pkg.sv -----
`default_nettype none

package nywc_pkg;

    localparam logic [14:0] CYCLE_RECIP     = 15'd27595;
    localparam logic [13:0] CYCLE_YEARS     = 14'd19;
    localparam logic [12:0] CYCLE_DAYS      = 13'd6939;
    localparam logic [14:0] CYCLE_PARTS     = 15'd17875;
    localparam logic [4:0]  MONTH_DAYS      = 5'd29;
    localparam logic [13:0] MONTH_PARTS     = 14'd13753;
    localparam logic [1:0]  EPOCH_DAYS      = 2'd2;
    localparam logic [12:0] EPOCH_PARTS     = 13'd5604;
    localparam logic [14:0] PARTS_PER_DAY   = 15'd25920;
    localparam logic [18:0] DAY_RECIP       = 19'd331402;
    localparam logic [10:0] PARTS_PER_HOUR  = 11'd1080;
    localparam logic [12:0] HOUR_RECIP      = 13'd7768;
    localparam logic [23:0] WEEK_RECIP      = 24'd9586981;
    localparam logic [2:0]  DAYS_PER_WEEK   = 3'd7;

    localparam logic [4:0]  LATE_HOUR       = 5'd18;
    localparam logic [4:0]  TUE_HOUR        = 5'd9;
    localparam logic [10:0] TUE_PART        = 11'd204;
    localparam logic [4:0]  MON_HOUR        = 5'd15;
    localparam logic [10:0] MON_PART        = 11'd589;

    localparam logic [2:0]  WD_SAT = 3'd0;
    localparam logic [2:0]  WD_SUN = 3'd1;
    localparam logic [2:0]  WD_MON = 3'd2;
    localparam logic [2:0]  WD_TUE = 3'd3;
    localparam logic [2:0]  WD_WED = 3'd4;
    localparam logic [2:0]  WD_THU = 3'd5;
    localparam logic [2:0]  WD_FRI = 3'd6;

    localparam logic [2:0]  REASON_NONE      = 3'd0;
    localparam logic [2:0]  REASON_LATE      = 3'd1;
    localparam logic [2:0]  REASON_LATE_WDAY = 3'd2;
    localparam logic [2:0]  REASON_TUESDAY   = 3'd3;
    localparam logic [2:0]  REASON_MONDAY    = 3'd4;
    localparam logic [2:0]  REASON_WEEKDAY   = 3'd5;

    typedef struct packed {
        logic [22:0] mdays;
        logic [2:0]  mwd;
        logic [4:0]  hour;
        logic [10:0] part;
        logic        leap;
        logic        post_leap;
    } molad_t;

    function automatic logic [7:0] months_before(input logic [4:0] r);
        logic [7:0] m;
        case (r)
            5'd0:    m = 8'd0;
            5'd1:    m = 8'd12;
            5'd2:    m = 8'd24;
            5'd3:    m = 8'd37;
            5'd4:    m = 8'd49;
            5'd5:    m = 8'd61;
            5'd6:    m = 8'd74;
            5'd7:    m = 8'd86;
            5'd8:    m = 8'd99;
            5'd9:    m = 8'd111;
            5'd10:   m = 8'd123;
            5'd11:   m = 8'd136;
            5'd12:   m = 8'd148;
            5'd13:   m = 8'd160;
            5'd14:   m = 8'd173;
            5'd15:   m = 8'd185;
            5'd16:   m = 8'd197;
            5'd17:   m = 8'd210;
            5'd18:   m = 8'd222;
            default: m = 8'd0;
        endcase
        return m;
    endfunction

    function automatic logic is_leap(input logic [4:0] pos);
        return (pos == 5'd0) || (pos == 5'd3) || (pos == 5'd6) || (pos == 5'd8) ||
               (pos == 5'd11) || (pos == 5'd14) || (pos == 5'd17);
    endfunction

    function automatic logic is_post_leap(input logic [4:0] pos);
        return (pos == 5'd1) || (pos == 5'd4) || (pos == 5'd7) || (pos == 5'd9) ||
               (pos == 5'd12) || (pos == 5'd15) || (pos == 5'd18);
    endfunction

    function automatic logic forbidden_day(input logic [2:0] wd);
        return (wd == WD_SUN) || (wd == WD_WED) || (wd == WD_FRI);
    endfunction

    function automatic logic [2:0] next_weekday(input logic [2:0] wd);
        return (wd == WD_FRI) ? WD_SAT : wd + 3'd1;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nywc_molad.sv -----
`default_nettype none

module nywc_molad (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [13:0]       in_year,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output nywc_pkg::molad_t       out_info
);

    logic [6:0]  vld_reg;
    logic [6:0]  adv;

    // stage 1
    logic [13:0] el_next;
    logic [28:0] p19_next;
    logic [13:0] el_reg;
    logic [9:0]  q_reg;
    logic        yz_reg;

    // stage 2
    logic [13:0] r_full_next;
    logic [4:0]  r_next;
    logic [4:0]  pos_next;
    logic [22:0] cd_reg;
    logic [23:0] cp_reg;
    logic [7:0]  mb_reg;
    logic        leap2_reg;
    logic        post2_reg;

    // stage 3
    logic [22:0] days0_reg;
    logic [24:0] x3_reg;
    logic        leap3_reg;
    logic        post3_reg;

    // stage 4
    logic [37:0] pd_next;
    logic [22:0] days4_reg;
    logic [24:0] x4_reg;
    logic [10:0] qd_reg;
    logic        leap4_reg;
    logic        post4_reg;

    // stage 5
    logic [24:0] rem_full_next;
    logic [22:0] mdays5_reg;
    logic [14:0] rem5_reg;
    logic        leap5_reg;
    logic        post5_reg;

    // stage 6
    logic [46:0] p7_next;
    logic [24:0] ph_next;
    logic [22:0] mdays6_reg;
    logic [14:0] rem6_reg;
    logic [20:0] qd7_reg;
    logic [4:0]  hr_reg;
    logic        leap6_reg;
    logic        post6_reg;

    // stage 7
    logic [22:0] mwd_full_next;
    logic [14:0] part_full_next;
    nywc_pkg::molad_t info_reg;

    always_comb begin
        adv[6] = !vld_reg[6] || out_ready;
        for (int k = 5; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k + 1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[6];
    assign out_info  = info_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < 7; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k - 1];
                end
            end
        end
    end

    // elapsed years and full cycles
    assign el_next  = (in_year == 14'd0) ? 14'd0 : in_year - 14'd1;
    assign p19_next = 29'(el_next) * 29'(nywc_pkg::CYCLE_RECIP);

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            el_reg <= el_next;
            q_reg  <= p19_next[28:19];
            yz_reg <= (in_year == 14'd0);
        end
    end

    // position in cycle, leap status, cycle contribution
    assign r_full_next = el_reg - 14'(14'(q_reg) * nywc_pkg::CYCLE_YEARS);
    assign r_next      = r_full_next[4:0];
    assign pos_next    = (yz_reg || r_next == 5'd18) ? 5'd0 : r_next + 5'd1;

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            cd_reg    <= 23'(q_reg) * 23'(nywc_pkg::CYCLE_DAYS);
            cp_reg    <= 24'(q_reg) * 24'(nywc_pkg::CYCLE_PARTS);
            mb_reg    <= nywc_pkg::months_before(r_next);
            leap2_reg <= nywc_pkg::is_leap(pos_next);
            post2_reg <= nywc_pkg::is_post_leap(pos_next);
        end
    end

    // add months within cycle and epoch
    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            days0_reg <= cd_reg + 23'(mb_reg) * 23'(nywc_pkg::MONTH_DAYS)
                       + 23'(nywc_pkg::EPOCH_DAYS);
            x3_reg    <= 25'(cp_reg) + 25'(mb_reg) * 25'(nywc_pkg::MONTH_PARTS)
                       + 25'(nywc_pkg::EPOCH_PARTS);
            leap3_reg <= leap2_reg;
            post3_reg <= post2_reg;
        end
    end

    // whole days in the parts sum
    assign pd_next = 38'(x3_reg[24:6]) * 38'(nywc_pkg::DAY_RECIP);

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            days4_reg <= days0_reg;
            x4_reg    <= x3_reg;
            qd_reg    <= pd_next[37:27];
            leap4_reg <= leap3_reg;
            post4_reg <= post3_reg;
        end
    end

    assign rem_full_next = x4_reg - 25'(qd_reg) * 25'(nywc_pkg::PARTS_PER_DAY);

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            mdays5_reg <= days4_reg + 23'(qd_reg);
            rem5_reg   <= rem_full_next[14:0];
            leap5_reg  <= leap4_reg;
            post5_reg  <= post4_reg;
        end
    end

    // weeks and hours
    assign p7_next = 47'(mdays5_reg) * 47'(nywc_pkg::WEEK_RECIP);
    assign ph_next = 25'(rem5_reg[14:3]) * 25'(nywc_pkg::HOUR_RECIP);

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            mdays6_reg <= mdays5_reg;
            rem6_reg   <= rem5_reg;
            qd7_reg    <= p7_next[46:26];
            hr_reg     <= ph_next[24:20];
            leap6_reg  <= leap5_reg;
            post6_reg  <= post5_reg;
        end
    end

    assign mwd_full_next  = mdays6_reg - 23'(qd7_reg) * 23'(nywc_pkg::DAYS_PER_WEEK);
    assign part_full_next = rem6_reg - 15'(hr_reg) * 15'(nywc_pkg::PARTS_PER_HOUR);

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            info_reg.mdays     <= mdays6_reg;
            info_reg.mwd       <= mwd_full_next[2:0];
            info_reg.hour      <= hr_reg;
            info_reg.part      <= part_full_next[10:0];
            info_reg.leap      <= leap6_reg;
            info_reg.post_leap <= post6_reg;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/new_year_weekday_calc.sv -----
// Throughput: one year per cycle unless m_tready stalls; seven molad stages plus one
// rule stage, each with its own valid bit, so bubbles close up under backpressure.
// Reset: aresetn low at a rising edge clears all valid bits; payload is not reset.
`default_nettype none

module new_year_weekday_calc (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // year[13:0], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // weekday[2:0], day_number[25:3],
                                        // molad_days[48:26], molad_weekday[51:49],
                                        // conj_hour[56:52], molad_part[67:57],
                                        // reason_code[70:68], zero pad
);

    logic             mol_valid;
    logic             mol_ready;
    nywc_pkg::molad_t mol;

    logic             out_vld_reg;
    logic [2:0]       wd_reg;
    logic [22:0]      day_reg;
    logic [22:0]      mdays_reg;
    logic [2:0]       mwd_reg;
    logic [4:0]       hour_reg;
    logic [10:0]      part_reg;
    logic [2:0]       reason_reg;

    logic [2:0]       wd_next;
    logic [1:0]       inc_next;
    logic [2:0]       reason_next;
    logic [2:0]       wd1;
    logic             adu;
    logic             tue_late;
    logic             mon_late;

    nywc_molad u_molad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_year   (s_tdata[13:0]),
        .out_valid (mol_valid),
        .out_ready (mol_ready),
        .out_info  (mol)
    );

    assign mol_ready = !out_vld_reg || m_tready;

    // postponement rules, first match wins
    always_comb begin
        adu      = nywc_pkg::forbidden_day(mol.mwd);
        wd1      = nywc_pkg::next_weekday(mol.mwd);
        tue_late = (mol.hour > nywc_pkg::TUE_HOUR) ||
                   (mol.hour == nywc_pkg::TUE_HOUR && mol.part >= nywc_pkg::TUE_PART);
        mon_late = (mol.hour > nywc_pkg::MON_HOUR) ||
                   (mol.hour == nywc_pkg::MON_HOUR && mol.part >= nywc_pkg::MON_PART);
        wd_next     = mol.mwd;
        inc_next    = 2'd0;
        reason_next = nywc_pkg::REASON_NONE;
        if (mol.hour >= nywc_pkg::LATE_HOUR && !adu) begin
            if (nywc_pkg::forbidden_day(wd1)) begin
                wd_next     = nywc_pkg::next_weekday(wd1);
                inc_next    = 2'd2;
                reason_next = nywc_pkg::REASON_LATE_WDAY;
            end else begin
                wd_next     = wd1;
                inc_next    = 2'd1;
                reason_next = nywc_pkg::REASON_LATE;
            end
        end else if (mol.mwd == nywc_pkg::WD_TUE && !mol.leap && tue_late) begin
            wd_next     = nywc_pkg::WD_THU;
            inc_next    = 2'd2;
            reason_next = nywc_pkg::REASON_TUESDAY;
        end else if (mol.post_leap && mol.mwd == nywc_pkg::WD_MON && mon_late) begin
            wd_next     = nywc_pkg::WD_TUE;
            inc_next    = 2'd1;
            reason_next = nywc_pkg::REASON_MONDAY;
        end else if (adu) begin
            wd_next     = wd1;
            inc_next    = 2'd1;
            reason_next = nywc_pkg::REASON_WEEKDAY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (mol_ready) begin
            out_vld_reg <= mol_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (mol_ready) begin
            wd_reg     <= wd_next;
            day_reg    <= mol.mdays + 23'(inc_next);
            mdays_reg  <= mol.mdays;
            mwd_reg    <= mol.mwd;
            hour_reg   <= mol.hour;
            part_reg   <= mol.part;
            reason_reg <= reason_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, reason_reg, part_reg, hour_reg, mwd_reg,
                       mdays_reg, day_reg, wd_reg};

`ifndef SYNTHESIS
    a_no_forbidden_day: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2:0] == nywc_pkg::WD_SUN ||
                       m_tdata[2:0] == nywc_pkg::WD_WED ||
                       m_tdata[2:0] == nywc_pkg::WD_FRI))
        else $error("new-year day on forbidden weekday");

    a_postpone_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[25:3] - m_tdata[48:26] <= 23'd2))
        else $error("postponement exceeds two days");

    a_no_postpone_same_wd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[70:68] == nywc_pkg::REASON_NONE) |->
        (m_tdata[2:0] == m_tdata[51:49] && m_tdata[25:3] == m_tdata[48:26]))
        else $error("day moved without a reason code");

    a_molad_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[56:52] <= 5'd23 && m_tdata[67:57] <= 11'd1079 &&
                      m_tdata[51:49] <= 3'd6))
        else $error("molad field out of range");
`endif

endmodule

`default_nettype wire

// ----- tb/nywc_checker.sv -----
`timescale 1ns / 1ps

module nywc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    output int          mismatches,
    output int          outstanding,
    output int          results_checked,
    output logic [5:0]  reasons_hit
);

    localparam longint unsigned LUNATION_PARTS = 64'd765433;
    localparam longint unsigned MOLAD_ZERO     = 64'd57444;
    localparam longint unsigned DAY_PARTS      = 64'd25920;
    localparam int              YEARS_PER_CYCLE  = 19;
    localparam int              MONTHS_PER_CYCLE = 235;

    localparam int MONTHS_INTO_CYCLE [19] = '{
        0, 12, 24, 37, 49, 61, 74, 86, 99, 111,
        123, 136, 148, 160, 173, 185, 197, 210, 222
    };

    typedef struct packed {
        logic [2:0]  weekday;
        logic [22:0] day_number;
        logic [22:0] molad_days;
        logic [2:0]  molad_weekday;
        logic [4:0]  conj_hour;
        logic [10:0] molad_part;
        logic [2:0]  reason_code;
    } new_year_t;

    new_year_t new_year_q[$];
    new_year_t want;
    new_year_t got;
    int        error_total = 0;
    int        checked_total = 0;
    logic [5:0] reason_mask = '0;

    function automatic logic closed_day(input logic [2:0] wd);
        return (wd == nywc_pkg::WD_SUN) || (wd == nywc_pkg::WD_WED) ||
               (wd == nywc_pkg::WD_FRI);
    endfunction

    function automatic logic [2:0] day_after(input logic [2:0] wd);
        return (wd == nywc_pkg::WD_FRI) ? nywc_pkg::WD_SAT : wd + 3'd1;
    endfunction

    function automatic new_year_t predict_new_year(input logic [13:0] year);
        longint unsigned done_years;
        longint unsigned months;
        longint unsigned parts_total;
        longint unsigned day_rest;
        logic [4:0]      pos;
        logic            leap;
        logic            after_leap;
        new_year_t       r;
        done_years  = (year == 14'd0) ? 0 : year - 1;
        months      = (done_years / YEARS_PER_CYCLE) * MONTHS_PER_CYCLE
                    + MONTHS_INTO_CYCLE[done_years % YEARS_PER_CYCLE];
        parts_total = months * LUNATION_PARTS + MOLAD_ZERO;
        r.molad_days    = 23'(parts_total / DAY_PARTS);
        day_rest        = parts_total % DAY_PARTS;
        r.conj_hour     = 5'(day_rest / nywc_pkg::PARTS_PER_HOUR);
        r.molad_part    = 11'(day_rest % nywc_pkg::PARTS_PER_HOUR);
        r.molad_weekday = 3'((parts_total / DAY_PARTS) % 7);
        pos        = 5'(year % YEARS_PER_CYCLE);
        leap       = pos inside {5'd0, 5'd3, 5'd6, 5'd8, 5'd11, 5'd14, 5'd17};
        after_leap = pos inside {5'd1, 5'd4, 5'd7, 5'd9, 5'd12, 5'd15, 5'd18};
        r.weekday     = r.molad_weekday;
        r.day_number  = r.molad_days;
        r.reason_code = nywc_pkg::REASON_NONE;
        if (r.conj_hour >= nywc_pkg::LATE_HOUR && !closed_day(r.molad_weekday)) begin
            r.weekday     = day_after(r.weekday);
            r.day_number  = r.day_number + 23'd1;
            r.reason_code = nywc_pkg::REASON_LATE;
            if (closed_day(r.weekday)) begin
                r.weekday     = day_after(r.weekday);
                r.day_number  = r.day_number + 23'd1;
                r.reason_code = nywc_pkg::REASON_LATE_WDAY;
            end
        end else if (r.molad_weekday == nywc_pkg::WD_TUE && !leap &&
                     (r.conj_hour > nywc_pkg::TUE_HOUR ||
                      (r.conj_hour == nywc_pkg::TUE_HOUR &&
                       r.molad_part >= nywc_pkg::TUE_PART))) begin
            r.weekday     = nywc_pkg::WD_THU;
            r.day_number  = r.day_number + 23'd2;
            r.reason_code = nywc_pkg::REASON_TUESDAY;
        end else if (after_leap && r.molad_weekday == nywc_pkg::WD_MON &&
                     (r.conj_hour > nywc_pkg::MON_HOUR ||
                      (r.conj_hour == nywc_pkg::MON_HOUR &&
                       r.molad_part >= nywc_pkg::MON_PART))) begin
            r.weekday     = nywc_pkg::WD_TUE;
            r.day_number  = r.day_number + 23'd1;
            r.reason_code = nywc_pkg::REASON_MONDAY;
        end else if (closed_day(r.molad_weekday)) begin
            r.weekday     = day_after(r.weekday);
            r.day_number  = r.day_number + 23'd1;
            r.reason_code = nywc_pkg::REASON_WEEKDAY;
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            error_total++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.weekday       = m_tdata[2:0];
                got.day_number    = m_tdata[25:3];
                got.molad_days    = m_tdata[48:26];
                got.molad_weekday = m_tdata[51:49];
                got.conj_hour     = m_tdata[56:52];
                got.molad_part    = m_tdata[67:57];
                got.reason_code   = m_tdata[70:68];
                if (new_year_q.size() == 0) begin
                    $error("result transaction with no pending year (day_number %0d)",
                           got.day_number);
                    error_total++;
                end else begin
                    want = new_year_q.pop_front();
                    compare_field("weekday", want.weekday, got.weekday);
                    compare_field("day_number", want.day_number, got.day_number);
                    compare_field("molad_days", want.molad_days, got.molad_days);
                    compare_field("molad_weekday", want.molad_weekday, got.molad_weekday);
                    compare_field("conj_hour", want.conj_hour, got.conj_hour);
                    compare_field("molad_part", want.molad_part, got.molad_part);
                    compare_field("reason_code", want.reason_code, got.reason_code);
                    if (want.reason_code <= nywc_pkg::REASON_WEEKDAY)
                        reason_mask[want.reason_code] = 1'b1;
                    checked_total++;
                end
            end
            if (s_tvalid && s_tready)
                new_year_q.push_back(predict_new_year(s_tdata[13:0]));
        end
        mismatches      <= error_total;
        outstanding     <= new_year_q.size();
        results_checked <= checked_total;
        reasons_hit     <= reason_mask;
    end

endmodule

// ----- tb/tb_new_year_weekday_calc.sv -----
`timescale 1ns / 1ps

module tb_new_year_weekday_calc;

    localparam int RANDOM_YEARS = 1500;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [1:0] RX_OPEN     = 2'd0;
    localparam logic [1:0] RX_COIN     = 2'd1;
    localparam logic [1:0] RX_SPARSE   = 2'd2;
    localparam logic [1:0] RX_PERIODIC = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    int         mismatches;
    int         outstanding;
    int         results_checked;
    logic [5:0] reasons_hit;

    int         burst_left = 0;
    logic [1:0] rx_mode = RX_OPEN;
    int         rx_left = 0;
    logic [7:0] rx_tick = '0;

    always #5 aclk = ~aclk;

    new_year_weekday_calc DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    nywc_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .reasons_hit     (reasons_hit)
    );

    always @(posedge aclk) begin
        rx_tick <= rx_tick + 8'd1;
        if (rx_left == 0) begin
            rx_mode <= 2'($urandom_range(0, 3));
            rx_left <= $urandom_range(50, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: m_tready <= rx_tick[3];
            default:     m_tready <= 1'b1;
        endcase
    end

    task automatic send_year(input logic [13:0] year);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, year};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int   pick;
        logic [13:0] year;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes, single-bit years, cycle boundary, a run of consecutive years
        send_year(14'd0);
        send_year(14'd1);
        send_year(14'd16383);
        for (int b = 1; b < 14; b++)
            send_year(14'd1 << b);
        send_year(14'h2AAA);
        send_year(14'h1555);
        send_year(14'd19);
        send_year(14'd20);
        for (int y = 5779; y < 5783; y++)
            send_year(14'(y));

        for (int n = 0; n < RANDOM_YEARS; n++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                year = 14'($urandom_range(0, 40));
            else if (pick == 1)
                year = 14'($urandom_range(16300, 16383));
            else
                year = 14'($urandom_range(1, 16383));
            send_year(year);
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d new-year results: directed extremes plus random years 0..16383",
                 results_checked);
        $display("Postponement codes seen, one bit per code from none up: %b",
                 reasons_hit[5:0]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
